// File: src/pcts_pkg.sv
// ----------------------------------------------------------------------------
// pcts_pkg
// Types, constants and sizing shared by the transfer setup block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcts_pkg;

    localparam int SECTOR_BYTES_DEF = 512;
    localparam int MAX_XFER_DEF     = 16384;

    // logical sector: 32-bit offset / 512 plus 28-bit start fits in 29 bits
    localparam int LSEC_W = 33;
    localparam int QUO_W  = 33;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OFFLINE = 2'd1;
    localparam logic [1:0] ST_PAST    = 2'd2;

    localparam logic [7:0] CMD_READ     = 8'h20;
    localparam logic [7:0] CMD_WRITE    = 8'h30;
    localparam logic [7:0] DH_FIXED_BIT = 8'h20;

    localparam logic [2:0] CFG_SPT    = 3'd0;
    localparam logic [2:0] CFG_HEADS  = 3'd1;
    localparam logic [2:0] CFG_ONLINE = 3'd2;

    typedef struct packed {
        logic        func;
        logic [31:0] byte_offset;
        logic [23:0] byte_length;
        logic [27:0] partition_start;
        logic [27:0] partition_end;
        logic        drive_select;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] cylinder;
        logic [7:0]  sector_number;
        logic [7:0]  drive_head;
        logic [5:0]  sector_count;
        logic [7:0]  command_code;
        logic [14:0] transfer_bytes;
    } rsp_t;

    // side data that rides along the divider chain
    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  nsec;
        logic        func;
        logic        drive;
        logic [7:0]  spt;
        logic [4:0]  heads;
    } side_t;

endpackage

`default_nettype wire

// File: src/pcts_div_cell.sv
// ----------------------------------------------------------------------------
// pcts_div_cell
// One restoring-division step: shifts one dividend bit in, subtracts divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module pcts_div_cell
    import pcts_pkg::*;
#(
    parameter int DW = 33,
    parameter int VW = 13,
    parameter int BIT = 0
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          vld_in,
    input  wire logic [DW-1:0] num_in,
    input  wire logic [VW-1:0] den_in,
    input  wire logic [VW:0]   rem_in,
    input  wire logic [DW-1:0] quo_in,
    input  wire side_t         side_in,
    output logic               vld_out,
    output logic      [DW-1:0] num_out,
    output logic      [VW-1:0] den_out,
    output logic      [VW:0]   rem_out,
    output logic      [DW-1:0] quo_out,
    output side_t              side_out
);

    logic [VW+1:0] trial;
    logic [VW+1:0] diff;
    logic [VW:0]   rem_next;
    logic [DW-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_in, num_in[BIT]};
        diff     = trial - {2'b00, den_in};
        quo_next = quo_in;
        if (!diff[VW+1])
        begin
            rem_next      = diff[VW:0];
            quo_next[BIT] = 1'b1;
        end
        else
        begin
            rem_next = trial[VW:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out <= 1'b0;
        end
        else
        begin
            vld_out <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        num_out  <= num_in;
        den_out  <= den_in;
        rem_out  <= rem_next;
        quo_out  <= quo_next;
        side_out <= side_in;
    end

endmodule

`default_nettype wire

// File: src/pcts_div_chain.sv
// ----------------------------------------------------------------------------
// pcts_div_chain
// Row of division cells, one quotient bit per cell, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module pcts_div_chain
    import pcts_pkg::*;
#(
    parameter int DW = 33,
    parameter int VW = 13
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          vld_in,
    input  wire logic [DW-1:0] num_in,
    input  wire logic [VW-1:0] den_in,
    input  wire side_t         side_in,
    output logic               vld_out,
    output logic      [DW-1:0] quo_out,
    output logic      [VW-1:0] rem_out,
    output side_t              side_out
);

    logic          vld_s  [DW+1];
    logic [DW-1:0] num_s  [DW+1];
    logic [VW-1:0] den_s  [DW+1];
    logic [VW:0]   rem_s  [DW+1];
    logic [DW-1:0] quo_s  [DW+1];
    side_t         side_s [DW+1];

    assign vld_s[0]  = vld_in;
    assign num_s[0]  = num_in;
    assign den_s[0]  = den_in;
    assign rem_s[0]  = '0;
    assign quo_s[0]  = '0;
    assign side_s[0] = side_in;

    for (genvar i = 0; i < DW; i++)
    begin : g_cell
        pcts_div_cell #(.DW(DW), .VW(VW), .BIT(DW-1-i)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .vld_in(vld_s[i]), .num_in(num_s[i]), .den_in(den_s[i]),
            .rem_in(rem_s[i]), .quo_in(quo_s[i]), .side_in(side_s[i]),
            .vld_out(vld_s[i+1]), .num_out(num_s[i+1]), .den_out(den_s[i+1]),
            .rem_out(rem_s[i+1]), .quo_out(quo_s[i+1]), .side_out(side_s[i+1])
        );
    end

    assign vld_out  = vld_s[DW];
    assign quo_out  = quo_s[DW];
    assign rem_out  = rem_s[DW][VW-1:0];
    assign side_out = side_s[DW];

endmodule

`default_nettype wire

// File: src/partition_chs_transfer_setup.sv
// ----------------------------------------------------------------------------
// partition_chs_transfer_setup
// Byte request to task-file values: sector math, clip, LBA to CHS.
// ----------------------------------------------------------------------------
// Pipeline: 70 register stages, namely 2 setup stages, two chains of 33 one-bit
// division cells (lsec / spt, then (lsec / spt) / heads), the register between
// the chains and the output register.
// Throughput: one word per cycle; busy is held low.
// Reset: geometry returns to 63 sectors, 16 heads, disk offline; pipe empties.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_chs_transfer_setup
    import pcts_pkg::*;
#(
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
    parameter int MAX_XFER     = MAX_XFER_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire req_t        req,
    output logic             done,
    output rsp_t             rsp,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int SB_SH = $clog2(SECTOR_BYTES);
    localparam int NS_W  = $clog2(MAX_XFER / SECTOR_BYTES + 1) + 1;

    logic [7:0] spt_reg;
    logic [4:0] heads_reg;
    logic       online_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg    <= 8'd63;
            heads_reg  <= 5'd16;
            online_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPT:    spt_reg    <= cfg_data;
                CFG_HEADS:  heads_reg  <= cfg_data[4:0];
                CFG_ONLINE: online_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: sector math
    logic              s1_vld_reg;
    logic [LSEC_W-1:0] s1_lsec_reg;
    logic [27:0]       s1_pend_reg;
    logic [NS_W-1:0]   s1_nsec_reg;
    side_t             s1_side_reg;

    logic [24:0]       blen_cap;
    logic [24:0]       nsec_full;
    side_t             side_next;

    always_comb
    begin
        blen_cap = (req.byte_length > 24'(MAX_XFER)) ? 25'(MAX_XFER)
                                                     : {1'b0, req.byte_length};
        nsec_full = (blen_cap + 25'(SECTOR_BYTES - 1)) >> SB_SH;
        side_next.status = online_reg ? ST_OK : ST_OFFLINE;
        side_next.nsec   = '0;
        side_next.func   = req.func;
        side_next.drive  = req.drive_select;
        side_next.spt    = (spt_reg == 8'd0) ? 8'd1 : spt_reg;
        side_next.heads  = (heads_reg == 5'd0) ? 5'd1 : heads_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_lsec_reg <= LSEC_W'(req.byte_offset >> SB_SH) + LSEC_W'(req.partition_start);
        s1_pend_reg <= req.partition_end;
        s1_nsec_reg <= nsec_full[NS_W-1:0];
        s1_side_reg <= side_next;
    end

    // stage 2: past-end check and clip
    logic              s2_vld_reg;
    logic [LSEC_W-1:0] s2_lsec_reg;
    side_t             s2_side_reg;
    side_t             s2_side_next;
    logic [LSEC_W-1:0] room;
    logic [LSEC_W-1:0] nsec_clip;

    always_comb
    begin
        room      = LSEC_W'(s1_pend_reg) - s1_lsec_reg;
        nsec_clip = (LSEC_W'(s1_nsec_reg) > room) ? room : LSEC_W'(s1_nsec_reg);
        s2_side_next      = s1_side_reg;
        s2_side_next.nsec = nsec_clip[5:0];
        if (s1_side_reg.status == ST_OK && s1_lsec_reg >= LSEC_W'(s1_pend_reg))
            s2_side_next.status = ST_PAST;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_lsec_reg <= s1_lsec_reg;
        s2_side_reg <= s2_side_next;
    end

    // divide by sectors per track
    logic              d1_vld;
    logic [QUO_W-1:0]  d1_quo;
    logic [7:0]        d1_rem;
    side_t             d1_side;

    pcts_div_chain #(.DW(QUO_W), .VW(8)) u_div_spt (
        .clk(clk), .rst_n(rst_n),
        .vld_in(s2_vld_reg), .num_in(s2_lsec_reg), .den_in(s2_side_reg.spt),
        .side_in(s2_side_reg),
        .vld_out(d1_vld), .quo_out(d1_quo), .rem_out(d1_rem), .side_out(d1_side)
    );

    // hold sector across the second chain
    logic [7:0] sec_dly_reg [QUO_W+1];

    always_ff @(posedge clk)
    begin
        sec_dly_reg[0] <= d1_rem + 8'd1;
        for (int k = 1; k <= QUO_W; k++)
            sec_dly_reg[k] <= sec_dly_reg[k-1];
    end

    logic              d1_vld_reg;
    logic [QUO_W-1:0]  d1_quo_reg;
    side_t             d1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d1_vld_reg <= 1'b0;
        else
            d1_vld_reg <= d1_vld;
    end

    always_ff @(posedge clk)
    begin
        d1_quo_reg  <= d1_quo;
        d1_side_reg <= d1_side;
    end

    // divide by heads: quotient is cylinder, remainder is head
    logic              d2_vld;
    logic [QUO_W-1:0]  d2_quo;
    logic [4:0]        d2_rem;
    side_t             d2_side;

    pcts_div_chain #(.DW(QUO_W), .VW(5)) u_div_heads (
        .clk(clk), .rst_n(rst_n),
        .vld_in(d1_vld_reg), .num_in(d1_quo_reg), .den_in(d1_side_reg.heads),
        .side_in(d1_side_reg),
        .vld_out(d2_vld), .quo_out(d2_quo), .rem_out(d2_rem), .side_out(d2_side)
    );

    // output register
    logic done_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    always_comb
    begin
        rsp_next = '0;
        rsp_next.status = d2_side.status;
        if (d2_side.status == ST_OK)
        begin
            rsp_next.cylinder       = d2_quo[15:0];
            rsp_next.sector_number  = sec_dly_reg[QUO_W];
            rsp_next.drive_head     = DH_FIXED_BIT | {3'b000, d2_side.drive, 4'b0000}
                                      | {3'b000, d2_rem};
            rsp_next.sector_count   = d2_side.nsec;
            rsp_next.command_code   = d2_side.func ? CMD_WRITE : CMD_READ;
            rsp_next.transfer_bytes = 15'(d2_side.nsec * SECTOR_BYTES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d2_vld;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// File: src/pcts_checker.sv
// ----------------------------------------------------------------------------
// pcts_checker
// Port-level checks of result words for the transfer setup block.
// ----------------------------------------------------------------------------
`default_nettype none

module pcts_checker
    import pcts_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t rsp
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status != 2'd3))
        else $error("bad status");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ST_OK |-> rsp.cylinder == 16'd0
            && rsp.sector_count == 6'd0 && rsp.command_code == 8'd0)
        else $error("failed word not cleared");

    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == ST_OK |-> rsp.sector_number != 8'd0
            && (rsp.command_code == CMD_READ || rsp.command_code == CMD_WRITE)
            && rsp.sector_count <= 6'd32)
        else $error("bad ok word");

endmodule

bind partition_chs_transfer_setup pcts_checker u_pcts_checker (
    .clk(clk), .rst_n(rst_n), .busy(busy), .done(done), .rsp(rsp)
);

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the transfer setup block: sends request words through the start/busy
// handshake, predicts each task-file result from the request and the current
// geometry, and compares it field by field with every done strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import pcts_pkg::*;

    localparam int LATENCY   = 70;
    localparam int SEC_BYTES = 512;
    localparam int XFER_CAP  = 16384;
    localparam int CYCLE_CAP = 400000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       req;
    logic       done;
    rsp_t       rsp;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    logic [7:0] geo_spt;
    logic [4:0] geo_heads;
    logic       geo_online;
    rsp_t       pending_rsp[$];
    int         mismatches = 0;
    int         cycles = 0;
    logic       calm;

    partition_chs_transfer_setup u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsp_t chs_of(req_t r);
        rsp_t        o;
        logic [63:0] spt;
        logic [63:0] hd;
        logic [63:0] blen;
        logic [63:0] nsec;
        logic [63:0] lsec;
        o = '0;
        spt = (geo_spt == 0) ? 64'd1 : 64'(geo_spt);
        hd = (geo_heads == 0) ? 64'd1 : 64'(geo_heads);
        if (!geo_online)
        begin
            o.status = ST_OFFLINE;
            return o;
        end
        blen = 64'(r.byte_length);
        if (blen > XFER_CAP)
            blen = XFER_CAP;
        nsec = (blen + SEC_BYTES - 1) / SEC_BYTES;
        lsec = 64'(r.byte_offset) / SEC_BYTES + 64'(r.partition_start);
        if (lsec >= 64'(r.partition_end))
        begin
            o.status = ST_PAST;
            return o;
        end
        if (lsec + nsec > 64'(r.partition_end))
            nsec = 64'(r.partition_end) - lsec;
        o.status = ST_OK;
        o.cylinder = 16'(lsec / (spt * hd));
        o.sector_number = 8'(lsec % spt + 1);
        o.drive_head = DH_FIXED_BIT | {3'b0, r.drive_select, 4'b0} | 8'((lsec / spt) % hd);
        o.sector_count = 6'(nsec);
        o.command_code = r.func ? CMD_WRITE : CMD_READ;
        o.transfer_bytes = 15'(nsec * SEC_BYTES);
        return o;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_t exp_w;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", rsp);
            end
            else
            begin
                exp_w = pending_rsp.pop_front();
                if (rsp.status !== exp_w.status || rsp.cylinder !== exp_w.cylinder
                    || rsp.sector_number !== exp_w.sector_number
                    || rsp.drive_head !== exp_w.drive_head
                    || rsp.sector_count !== exp_w.sector_count
                    || rsp.command_code !== exp_w.command_code
                    || rsp.transfer_bytes !== exp_w.transfer_bytes)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", exp_w, rsp);
                end
            end
        end
    end

    task automatic send_req(req_t r);
        while (!calm && $urandom_range(99) < 24)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_rsp.push_back(chs_of(r));
    endtask

    task automatic drain();
        int n;
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        for (n = 0; n < LATENCY + 10; n++)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SPT:    geo_spt = val;
            CFG_HEADS:  geo_heads = val[4:0];
            CFG_ONLINE: geo_online = val[0];
            default:    ;
        endcase
        @(posedge clk);
    endtask

    function automatic req_t rand_req();
        req_t r;
        r.func = 1'($urandom);
        r.drive_select = 1'($urandom);
        r.byte_offset = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200000);
        r.byte_length = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(20000));
        r.partition_start = ($urandom_range(3) == 0) ? 28'($urandom) : 28'($urandom_range(5000));
        case ($urandom_range(3))
            0:       r.partition_end = 28'($urandom);
            1:       r.partition_end = 28'(r.byte_offset / SEC_BYTES + r.partition_start
                                           + $urandom_range(40));
            default: r.partition_end = 28'(r.byte_offset / SEC_BYTES + r.partition_start
                                           + $urandom_range(100000));
        endcase
        return r;
    endfunction

    task automatic test_offline();
        req_t r;
        r = '1;
        send_req(r);
        r = '0;
        send_req(r);
        drain();
    endtask

    task automatic test_directed();
        req_t r;
        write_reg(CFG_ONLINE, 8'd1);
        r = '0;
        r.partition_end = 28'd100;
        send_req(r);
        r.func = 1'b1;
        r.drive_select = 1'b1;
        r.byte_length = 24'hFFFFFF;
        send_req(r);
        r.byte_length = 24'd513;
        r.byte_offset = 32'd99 * SEC_BYTES;
        send_req(r);
        r.byte_offset = 32'd100 * SEC_BYTES;
        send_req(r);
        r = '1;
        send_req(r);
        r.partition_end = '1;
        r.partition_start = 28'd0;
        send_req(r);
        r.byte_offset = 32'hFFFF_FFFF;
        r.partition_start = 28'hFFF_FFFF;
        r.partition_end = 28'hFFF_FFFF;
        send_req(r);
        r = '0;
        r.partition_start = 28'h0FF_FFFF;
        r.partition_end = 28'hFFF_FFFF;
        r.byte_length = 24'd16384;
        send_req(r);
        drain();
    endtask

    task automatic test_geometry();
        int g;
        int k;
        for (g = 0; g < 6; g++)
        begin
            case (g)
                0: begin write_reg(CFG_SPT, 8'd255); write_reg(CFG_HEADS, 8'd16); end
                1: begin write_reg(CFG_SPT, 8'd1);   write_reg(CFG_HEADS, 8'd1);  end
                2: begin write_reg(CFG_SPT, 8'd0);   write_reg(CFG_HEADS, 8'd0);  end
                3: begin write_reg(CFG_SPT, 8'd17);  write_reg(CFG_HEADS, 8'd31); end
                default:
                begin
                    write_reg(CFG_SPT, 8'($urandom));
                    write_reg(CFG_HEADS, 8'($urandom));
                end
            endcase
            for (k = 0; k < 4; k++)
                send_req(rand_req());
            drain();
        end
    endtask

    task automatic test_random();
        int k;
        for (k = 0; k < 480; k++)
        begin
            if (k % 80 == 0)
            begin
                drain();
                write_reg(CFG_SPT, 8'($urandom));
                write_reg(CFG_HEADS, 8'($urandom_range(31)));
                write_reg(CFG_ONLINE, ($urandom_range(7) == 0) ? 8'd0 : 8'd1);
            end
            calm = (k >= 200 && k < 280);
            send_req(rand_req());
        end
        calm = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 1'b0;
        geo_spt = 8'd63;
        geo_heads = 5'd16;
        geo_online = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_offline();
        test_directed();
        test_geometry();
        test_random();
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
